[design/nearest_resample_luma_density_top_macros.svh]
// Assertion macros used by the checker of the resampler block.
`ifndef NEAREST_RESAMPLE_LUMA_DENSITY_TOP_MACROS_SVH
`define NEAREST_RESAMPLE_LUMA_DENSITY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NRLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/nrld_pkg.sv]
// Types, constants and codes of the nearest-neighbor luma density resampler.
`timescale 1ns / 1ps
package nrld_pkg;

	localparam int MAX_SRC_WIDTH  = 128;
	localparam int MAX_SRC_HEIGHT = 128;
	localparam int MAX_DST_DIM    = 1024;

	localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 4 * CH_W;
	localparam int COORD_W = 10;
	localparam int SDIM_W  = 8;
	localparam int DDIM_W  = 11;
	localparam int DENS_W  = 16;
	localparam int SX_W    = $clog2(MAX_SRC_WIDTH);
	localparam int SY_W    = $clog2(MAX_SRC_HEIGHT);

	localparam int TDATA_IN_W  = 56;
	localparam int TUSER_IN_W  = 2;
	localparam int TDATA_OUT_W = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = DDIM_W;

	// divider: dividend bits shifted in MSB first, remainder as wide as the divisor
	localparam int DIVD_W  = COORD_W + SDIM_W;
	localparam int DIVR_W  = 26;
	localparam int DSTEP_W = 4;
	localparam logic [DSTEP_W-1:0] COORD_STEPS = DSTEP_W'(DIVD_W / 2);
	localparam logic [DSTEP_W-1:0] LUMA_STEPS  = DSTEP_W'(DENS_W / 2);

	localparam int LUMA_W = 18;
	localparam int PROD_W = LUMA_W + CH_W;
	localparam logic [9:0] COEF_R = 10'd299;
	localparam logic [9:0] COEF_G = 10'd587;
	localparam logic [9:0] COEF_B = 10'd114;
	localparam logic [DIVR_W-1:0] LUMA_DEN = DIVR_W'(65025000);

	localparam logic [DENS_W-1:0] DENS_HALF = 16'd16384;
	localparam logic [DENS_W-1:0] DENS_MIN  = 16'd3277;
	localparam logic [DENS_W-1:0] DENS_MAX  = 16'd32768;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic q_start;
		logic res_half;
		logic idx;
		logic rd;
		logic luma1;
		logic luma_start;
		logic res_luma;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic no_image;
		logic div_busy;
		logic hit;
		logic out_free;
	} dp_status_t;

endpackage

[design/nrld_div.sv]
// Restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
module nrld_div
	import nrld_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIVR_W-1:0]  divisor,
	input  logic [DIVR_W-1:0]  rem_init,
	input  logic [DIVD_W-1:0]  bits_init,
	input  logic [DSTEP_W-1:0] steps,
	output logic               busy,
	output logic [DIVD_W-1:0]  quot
);

	logic [DSTEP_W-1:0] count_q;
	logic [DIVR_W-1:0]  rem_q;
	logic [DIVR_W-1:0]  div_q;
	logic [DIVD_W-1:0]  bits_q;
	logic [DIVD_W-1:0]  quot_q;

	logic [DIVR_W:0]   r1, r2;
	logic [DIVR_W-1:0] r1n, r2n;
	logic              ge1, ge2;

	always_comb begin
		r1  = {rem_q, bits_q[DIVD_W-1]};
		ge1 = r1 >= {1'b0, div_q};
		r1n = ge1 ? DIVR_W'(r1 - {1'b0, div_q}) : r1[DIVR_W-1:0];
		r2  = {r1n, bits_q[DIVD_W-2]};
		ge2 = r2 >= {1'b0, div_q};
		r2n = ge2 ? DIVR_W'(r2 - {1'b0, div_q}) : r2[DIVR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= steps;
		end else if (count_q != '0) begin
			count_q <= count_q - DSTEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			div_q  <= divisor;
			bits_q <= bits_init;
			quot_q <= '0;
		end else if (count_q != '0) begin
			rem_q  <= r2n;
			bits_q <= {bits_q[DIVD_W-3:0], 2'b00};
			quot_q <= {quot_q[DIVD_W-3:0], ge1, ge2};
		end
	end

	assign busy = count_q != '0;
	assign quot = quot_q;

endmodule

[design/nrld_datapath.sv]
// Datapath: configuration, image store, coordinate mapping, luma density, output register.
`timescale 1ns / 1ps
module nrld_datapath
	import nrld_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	input  logic [TUSER_IN_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status
);

	logic [SDIM_W-1:0] src_w_q, src_h_q;
	logic [DDIM_W-1:0] dst_w_q, dst_h_q;
	logic [CNT_W-1:0]  loaded_q;
	logic [ADDR_W-1:0] idx_q;
	logic [PIX_W-1:0]  rd_q;
	logic [LUMA_W-1:0] l_q;
	logic [CH_W-1:0]   a_q;
	logic [DENS_W-1:0] res_q;
	logic              m_valid_q;
	logic [DENS_W-1:0] m_data_q;

	logic [PIX_W-1:0] mem [STORE_DEPTH];

	logic [SDIM_W-1:0]  sw, sh, swm1, shm1;
	logic [DDIM_W-1:0]  dw, dh;
	logic [COORD_W-1:0] tx, ty;
	logic [PIX_W-1:0]   pix_in;
	logic               sof;
	logic               full;
	logic [SX_W-1:0]    sx;
	logic [SY_W-1:0]    sy;
	logic [CNT_W-1:0]   idx_full;
	logic [PROD_W-1:0]  prod;
	logic [DIVD_W-1:0]  qx, qy;
	logic               busy_x, busy_y;
	logic [DIVR_W-1:0]  div0_divisor, div0_rem;
	logic [DIVD_W-1:0]  div0_bits;
	logic [DSTEP_W-1:0] div0_steps;

	assign pix_in = s_tdata[PIX_W-1:0];
	assign tx     = s_tdata[PIX_W +: COORD_W];
	assign ty     = s_tdata[PIX_W+COORD_W +: COORD_W];
	assign sof    = s_tuser[1];

	// saturate the configured dimensions; a zero target dimension counts as one
	always_comb begin
		sw = (src_w_q > SDIM_W'(MAX_SRC_WIDTH)) ? SDIM_W'(MAX_SRC_WIDTH) : src_w_q;
		sh = (src_h_q > SDIM_W'(MAX_SRC_HEIGHT)) ? SDIM_W'(MAX_SRC_HEIGHT) : src_h_q;
		priority if (dst_w_q == '0) dw = DDIM_W'(1);
		else if (dst_w_q > DDIM_W'(MAX_DST_DIM)) dw = DDIM_W'(MAX_DST_DIM);
		else dw = dst_w_q;
		priority if (dst_h_q == '0) dh = DDIM_W'(1);
		else if (dst_h_q > DDIM_W'(MAX_DST_DIM)) dh = DDIM_W'(MAX_DST_DIM);
		else dh = dst_h_q;
		swm1 = sw - SDIM_W'(1);
		shm1 = sh - SDIM_W'(1);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= '0;
			src_h_q <= '0;
			dst_w_q <= DDIM_W'(64);
			dst_h_q <= DDIM_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_w_q <= cfg_data[SDIM_W-1:0];
				REG_SRC_HEIGHT: src_h_q <= cfg_data[SDIM_W-1:0];
				REG_DST_WIDTH:  dst_w_q <= cfg_data;
				REG_DST_HEIGHT: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// image store: writes on load requests, registered read
	assign full = loaded_q >= CNT_W'(STORE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (cmd.load) begin
			if (sof) loaded_q <= CNT_W'(1);
			else if (!full) loaded_q <= loaded_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (sof) mem[0] <= pix_in;
			else if (!full) mem[loaded_q[ADDR_W-1:0]] <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= mem[idx_q];
	end

	// divider 0 maps the column, then serves the luma scaling
	always_comb begin
		if (cmd.luma_start) begin
			div0_divisor = LUMA_DEN;
			div0_rem     = DIVR_W'(prod >> 1);
			div0_bits    = {prod[0], {(DIVD_W-1){1'b0}}};
			div0_steps   = LUMA_STEPS;
		end else begin
			div0_divisor = DIVR_W'(dw);
			div0_rem     = '0;
			div0_bits    = DIVD_W'(tx) * DIVD_W'(sw);
			div0_steps   = COORD_STEPS;
		end
	end

	nrld_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.q_start | cmd.luma_start),
		.divisor   (div0_divisor),
		.rem_init  (div0_rem),
		.bits_init (div0_bits),
		.steps     (div0_steps),
		.busy      (busy_x),
		.quot      (qx)
	);

	nrld_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.q_start),
		.divisor   (DIVR_W'(dh)),
		.rem_init  ('0),
		.bits_init (DIVD_W'(ty) * DIVD_W'(sh)),
		.steps     (COORD_STEPS),
		.busy      (busy_y),
		.quot      (qy)
	);

	// clamp to the last column and row, form the raster index
	always_comb begin
		sx = (qx > DIVD_W'(swm1)) ? SX_W'(swm1) : SX_W'(qx);
		sy = (qy > DIVD_W'(shm1)) ? SY_W'(shm1) : SY_W'(qy);
		idx_full = CNT_W'(sy) * CNT_W'(sw) + CNT_W'(sx);
	end

	always_ff @(posedge clk) begin
		if (cmd.idx) idx_q <= idx_full[ADDR_W-1:0];
	end

	// luma: weighted channel sum, then times alpha
	always_ff @(posedge clk) begin
		if (cmd.luma1) begin
			l_q <= LUMA_W'(COEF_R) * LUMA_W'(rd_q[0 +: CH_W])
				+ LUMA_W'(COEF_G) * LUMA_W'(rd_q[CH_W +: CH_W])
				+ LUMA_W'(COEF_B) * LUMA_W'(rd_q[2*CH_W +: CH_W]);
			a_q <= rd_q[3*CH_W +: CH_W];
		end
	end

	assign prod = PROD_W'(l_q) * PROD_W'(a_q);

	always_ff @(posedge clk) begin
		if (cmd.res_half) begin
			res_q <= DENS_HALF;
		end else if (cmd.res_luma) begin
			priority if (qx < DIVD_W'(DENS_MIN)) res_q <= DENS_MIN;
			else if (qx > DIVD_W'(DENS_MAX)) res_q <= DENS_MAX;
			else res_q <= DENS_W'(qx);
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) m_data_q <= res_q;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign status.no_image = (sw == '0) || (sh == '0);
	assign status.div_busy = busy_x | busy_y;
	assign status.hit      = CNT_W'(idx_q) < loaded_q;
	assign status.out_free = !m_valid_q || m_tready;

endmodule

[design/nrld_ctrl.sv]
// Controller: sequences loads and queries through the datapath.
`timescale 1ns / 1ps
module nrld_ctrl
	import nrld_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TUSER_IN_W-1:0] s_tuser,
	input  dp_status_t            status,
	output ctrl_cmd_t             cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIVC = 3'd1;
	localparam logic [2:0] S_IDX  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_LUM1 = 3'd4;
	localparam logic [2:0] S_LUM2 = 3'd5;
	localparam logic [2:0] S_DIVL = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;
	logic       accept;

	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (s_tuser[0] == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else if (status.no_image) begin
						cmd.res_half = 1'b1;
						state_d      = S_DONE;
					end else begin
						cmd.q_start = 1'b1;
						state_d     = S_DIVC;
					end
				end
			end
			S_DIVC: begin
				if (!status.div_busy) state_d = S_IDX;
			end
			S_IDX: begin
				cmd.idx = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				// a pixel not yet loaded answers one half
				if (status.hit) begin
					cmd.rd  = 1'b1;
					state_d = S_LUM1;
				end else begin
					cmd.res_half = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_LUM1: begin
				cmd.luma1 = 1'b1;
				state_d   = S_LUM2;
			end
			S_LUM2: begin
				cmd.luma_start = 1'b1;
				state_d        = S_DIVL;
			end
			S_DIVL: begin
				if (!status.div_busy) begin
					cmd.res_luma = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

[design/nearest_resample_luma_density_top.sv]
// Top level of the nearest-neighbor RGBA to luma density resampler.
//
// Input stream (s_*): each request is a load or a query, chosen by s_tuser[0].
// A load writes one RGBA pixel at the next raster position of the image store
// (s_tuser[1] restarts at pixel zero) and gives no result.
// A query maps (target_x, target_y) nearest-neighbor onto the source image and
// returns one Q1.15 density on the output stream (m_*).
// Configuration (cfg_*): source and target dimensions, to be written while idle;
// the block itself does not enforce this. A query runs two coordinate divisions
// side by side at two quotient bits per cycle (9 steps), then index, store read,
// luma sum, product and an 8-step scaling division on the shared divider, then
// the output register. A query with no image answers one half directly, one on
// an unloaded pixel answers one half once its index is formed. One request is
// worked at a time: a query holds off the input until its result has gone to the
// output register, so a result may wait for the receiver while new requests are
// accepted. If the receiver stalls while a second query completes, that query
// holds until the output register frees. Reset empties the load count and sets
// the state, divider count, configuration and output-valid registers to their
// reset values; the image store is not cleared, only read below the load count.
`timescale 1ns / 1ps
module nearest_resample_luma_density_top
	import nrld_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// red, green, blue, alpha, target_x, target_y, zero pad
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	// req_type, start_of_image
	input  logic [TUSER_IN_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// density
	output logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	nrld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	nrld_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

[design/nrld_checker.sv]
// Port-level checker for the resampler top level, bound to every instance.
`timescale 1ns / 1ps
`include "nearest_resample_luma_density_top_macros.svh"
module nrld_checker
	import nrld_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [TUSER_IN_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata
);

	`NRLD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`NRLD_ASSERT_IMP(a_dens_range, m_tvalid, (m_tdata >= DENS_MIN) && (m_tdata <= DENS_MAX), "density out of range")
	`NRLD_ASSERT_NEXT(a_load_no_result, s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD) && !m_tvalid, !m_tvalid, "load produced a result")
	`NRLD_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser[0] == REQ_QUERY), !s_tready, "request taken during a query")

endmodule

bind nearest_resample_luma_density_top nrld_checker u_nrld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
